@@ rtl/core/cir_pkg.sv @@
// ----------------------------------------------------------------------------
// cir_pkg: shared types and constants of the contact impulse resolver
// Holds the body record stored in the body table, the widths of the shared
// multiplier and divider, the function and register codes, and saturation.
// ----------------------------------------------------------------------------
package cir_pkg;

  // Function codes of an input beat.
  localparam logic [2:0] FUNC_WR_POS  = 3'd0;
  localparam logic [2:0] FUNC_WR_VEL  = 3'd1;
  localparam logic [2:0] FUNC_WR_IM   = 3'd2;
  localparam logic [2:0] FUNC_CONTACT = 3'd3;
  localparam logic [2:0] FUNC_RD_BODY = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_RESTITUTION = 2'd0;
  localparam logic [1:0] REG_PERCENT     = 2'd1;
  localparam logic [1:0] REG_SLOP        = 2'd2;

  localparam logic [16:0] RESTITUTION_RST = 17'd32768;
  localparam logic [16:0] PERCENT_RST     = 17'd13107;
  localparam logic [30:0] SLOP_RST        = 31'd655;

  // Shared multiplier: 33 x 33 signed, registered product.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  // Wide accumulator and saturation input width.
  localparam int ACC_W  = PROD_W + 2;
  // Shared divider: unsigned magnitude over the inverse-mass sum.
  localparam int DVD_W  = 64;
  localparam int DVS_W  = 32;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic        [30:0] inv_mass;
  } body_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > ACC_W'(64'sh7FFF_FFFF)) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -ACC_W'(64'sh8000_0000)) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/contact_impulse_resolver.sv @@
// ----------------------------------------------------------------------------
// contact_impulse_resolver: impulse contact resolution with position fix-up
// A body table (position and velocity in signed fixed point, inverse mass
// unsigned) with load, read-back and contact commands, worked by a small
// sequencer around a shared multiplier and a shared serial divider.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                       Payload
// input     in         start & !busy                   in_func .. in_scalar
// result    out        out_strobe, one cycle per beat  out_body .. out_last
// config    in/out     psel & penable & pwrite, APB    paddr, pwdata, prdata
//
// A load beat reads both table entries and then writes body A's entry back;
// a read-back beat issues its result after the reads. A contact beat runs
// four divisions by the inverse-mass sum through the one restoring divider
// at a bit a cycle, and its products go through the shared multiplier.
// busy stays high for the whole of a beat; results are issued as strobes
// and the receiver cannot stall them. Reset clears the sequencer and the
// configuration registers; the body table holds no reset value.
// ----------------------------------------------------------------------------
module contact_impulse_resolver #(
  parameter int BODY_COUNT = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_func,
  input  logic [5:0]         in_body_a,
  input  logic [5:0]         in_body_b,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic [30:0]        in_scalar,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic               out_strobe,
  output logic [5:0]         out_body,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z,
  output logic               out_last
);

  localparam int AW    = $clog2(BODY_COUNT);
  localparam int NBODY = 64;
  localparam logic [1:0] LAST_AXIS = 2'd2;

  // Sequencer states, one-hot.
  typedef enum logic [26:0] {
    ST_IDLE = 27'd1 << 0,  ST_RDA  = 27'd1 << 1,  ST_RDB  = 27'd1 << 2,
    ST_LDB  = 27'd1 << 3,  ST_WBW  = 27'd1 << 4,  ST_RMUL = 27'd1 << 5,
    ST_RACC = 27'd1 << 6,  ST_JMUL = 27'd1 << 7,  ST_JDST = 27'd1 << 8,
    ST_JDWT = 27'd1 << 9,  ST_IMUL = 27'd1 << 10, ST_IMPS = 27'd1 << 11,
    ST_VAM  = 27'd1 << 12, ST_VAU  = 27'd1 << 13, ST_VBM  = 27'd1 << 14,
    ST_VBU  = 27'd1 << 15, ST_CDM  = 27'd1 << 16, ST_CDS  = 27'd1 << 17,
    ST_CMUL = 27'd1 << 18, ST_CDST = 27'd1 << 19, ST_CDWT = 27'd1 << 20,
    ST_PAM  = 27'd1 << 21, ST_PAU  = 27'd1 << 22, ST_PBM  = 27'd1 << 23,
    ST_PBU  = 27'd1 << 24, ST_WBA  = 27'd1 << 25, ST_WBB  = 27'd1 << 26
  } state_t;

  state_t state_r, state_nxt;

  // Body indices arrive as six bits and are folded into the table size by
  // a constant lookup worked out at elaboration.
  logic [5:0] body_map [NBODY];
  for (genvar i = 0; i < NBODY; i++) begin : g_map
    localparam int MAPPED = i % BODY_COUNT;
    assign body_map[i] = 6'(MAPPED);
  end

  // Configuration registers.
  logic [16:0] restitution_r;
  logic [16:0] percent_r;
  logic [30:0] slop_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restitution_r <= cir_pkg::RESTITUTION_RST;
      percent_r     <= cir_pkg::PERCENT_RST;
      slop_r        <= cir_pkg::SLOP_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        cir_pkg::REG_RESTITUTION: restitution_r <= pwdata[16:0];
        cir_pkg::REG_PERCENT:     percent_r     <= pwdata[16:0];
        cir_pkg::REG_SLOP:        slop_r        <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cir_pkg::REG_RESTITUTION: prdata = {15'd0, restitution_r};
      cir_pkg::REG_PERCENT:     prdata = {15'd0, percent_r};
      cir_pkg::REG_SLOP:        prdata = {1'b0, slop_r};
      default:                  prdata = '0;
    endcase
  end

  // Working copy of the command and of both bodies.
  logic [2:0]         func_r;
  logic [5:0]         a_r, b_r;
  logic               same_r;
  logic [30:0]        pen_r;
  logic signed [31:0] n_r  [3];
  logic signed [31:0] va_r [3];
  logic signed [31:0] vb_r [3];
  logic signed [31:0] pa_r [3];
  logic signed [31:0] pb_r [3];
  logic [30:0]        ima_r, imb_r;
  logic [1:0]         k_r;
  logic signed [cir_pkg::ACC_W-1:0] acc_r;
  logic signed [31:0] j_r, imp_r, cd_r, c_r;
  logic               cneg_r;

  // Result registers.
  logic               out_strobe_r;
  logic               out_last_r;
  logic [5:0]         out_body_r;
  logic signed [31:0] out_pos_r [3];
  logic signed [31:0] out_vel_r [3];

  // Shared units.
  logic signed [cir_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [cir_pkg::PROD_W-1:0] prod;
  logic                              div_start;
  logic [cir_pkg::DVD_W-1:0]         div_dvd;
  logic [cir_pkg::DVS_W-1:0]         im_sum;
  cir_pkg::div_stat_t                div_stat;
  logic [cir_pkg::DVD_W-1:0]         div_q;

  cir_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  cir_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (im_sum),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Body table, one record per entry.
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  cir_pkg::body_t               ram_wdata, ram_rdata;

  cir_ram #(
    .WIDTH ($bits(cir_pkg::body_t)),
    .DEPTH (BODY_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Per-axis selections and derived values.
  logic signed [31:0]               n_k, va_k, vb_k, pa_k, pb_k;
  logic signed [31:0]               rel_k, van_s;
  logic signed [cir_pkg::PROD_W-1:0] prod_sh, prod_mag;
  logic [31:0]                      excess;
  logic signed [32:0]               pen_diff;

  assign n_k  = n_r[k_r];
  assign va_k = va_r[k_r];
  assign vb_k = vb_r[k_r];
  assign pa_k = pa_r[k_r];
  assign pb_k = pb_r[k_r];

  assign rel_k   = cir_pkg::sat32(cir_pkg::ACC_W'(vb_k - va_k));
  assign van_s   = cir_pkg::sat32(acc_r);
  assign prod_sh = prod >>> FRAC_BITS;
  assign prod_mag = prod[cir_pkg::PROD_W-1] ? -prod : prod;
  assign im_sum  = {1'b0, ima_r} + {1'b0, imb_r};
  assign pen_diff = $signed({2'b00, pen_r}) - $signed({2'b00, slop_r});
  assign excess  = pen_diff[32] ? 32'd0 : pen_diff[31:0];
  assign busy    = (state_r != ST_IDLE);

  // Saturate a quotient magnitude with its sign to 32 bits.
  function automatic logic signed [31:0] sat_q(input logic [cir_pkg::DVD_W-1:0] q,
                                               input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (q > cir_pkg::DVD_W'(64'h8000_0000)) begin
        r = 32'sh8000_0000;
      end else begin
        r = -$signed(q[31:0]);
      end
    end else begin
      if (q > cir_pkg::DVD_W'(64'h7FFF_FFFF)) begin
        r = 32'sh7FFF_FFFF;
      end else begin
        r = $signed(q[31:0]);
      end
    end
    return r;
  endfunction

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_RMUL: begin
        mul_a = cir_pkg::MUL_W'(rel_k);
        mul_b = cir_pkg::MUL_W'(n_k);
      end
      ST_JMUL: begin
        // (1 + e) times the closing speed, which is never negative here.
        mul_a = (cir_pkg::MUL_W'(1) <<< FRAC_BITS)
              + $signed({{(cir_pkg::MUL_W-17){1'b0}}, restitution_r});
        mul_b = -cir_pkg::MUL_W'(van_s);
      end
      ST_IMUL: begin
        mul_a = cir_pkg::MUL_W'(n_k);
        mul_b = cir_pkg::MUL_W'(j_r);
      end
      ST_VAM: begin
        mul_a = cir_pkg::MUL_W'(imp_r);
        mul_b = $signed({2'b00, ima_r});
      end
      ST_VBM: begin
        mul_a = cir_pkg::MUL_W'(imp_r);
        mul_b = $signed({2'b00, imb_r});
      end
      ST_CDM: begin
        mul_a = $signed({1'b0, excess});
        mul_b = $signed({{(cir_pkg::MUL_W-17){1'b0}}, percent_r});
      end
      ST_CMUL: begin
        mul_a = cir_pkg::MUL_W'(n_k);
        mul_b = cir_pkg::MUL_W'(cd_r);
      end
      ST_PAM: begin
        mul_a = cir_pkg::MUL_W'(c_r);
        mul_b = $signed({2'b00, ima_r});
      end
      ST_PBM: begin
        mul_a = cir_pkg::MUL_W'(c_r);
        mul_b = $signed({2'b00, imb_r});
      end
      default: ;
    endcase
  end

  assign div_start = (state_r == ST_JDST) || (state_r == ST_CDST);
  assign div_dvd   = prod_mag[cir_pkg::DVD_W-1:0];

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_RDA;
      ST_RDA:  state_nxt = ST_RDB;
      ST_RDB:  state_nxt = ST_LDB;
      ST_LDB: begin
        case (func_r)
          cir_pkg::FUNC_WR_POS,
          cir_pkg::FUNC_WR_VEL,
          cir_pkg::FUNC_WR_IM:   state_nxt = ST_WBW;
          cir_pkg::FUNC_CONTACT: state_nxt = ST_RMUL;
          default:               state_nxt = ST_IDLE;
        endcase
      end
      ST_WBW:  state_nxt = ST_IDLE;
      ST_RMUL: state_nxt = ST_RACC;
      ST_RACC: state_nxt = (k_r == LAST_AXIS) ? ST_JMUL : ST_RMUL;
      ST_JMUL: begin
        // Separating bodies, or two fixed bodies, leave the table alone.
        if (van_s > 0 || im_sum == '0) begin
          state_nxt = ST_WBA;
        end else begin
          state_nxt = ST_JDST;
        end
      end
      ST_JDST: state_nxt = ST_JDWT;
      ST_JDWT: if (div_stat.done) state_nxt = ST_IMUL;
      ST_IMUL: state_nxt = ST_IMPS;
      ST_IMPS: state_nxt = ST_VAM;
      ST_VAM:  state_nxt = ST_VAU;
      ST_VAU:  state_nxt = ST_VBM;
      ST_VBM:  state_nxt = ST_VBU;
      ST_VBU:  state_nxt = (k_r == LAST_AXIS) ? ST_CDM : ST_IMUL;
      ST_CDM:  state_nxt = ST_CDS;
      ST_CDS:  state_nxt = ST_CMUL;
      ST_CMUL: state_nxt = ST_CDST;
      ST_CDST: state_nxt = ST_CDWT;
      ST_CDWT: if (div_stat.done) state_nxt = ST_PAM;
      ST_PAM:  state_nxt = ST_PAU;
      ST_PAU:  state_nxt = ST_PBM;
      ST_PBM:  state_nxt = ST_PBU;
      ST_PBU:  state_nxt = (k_r == LAST_AXIS) ? ST_WBA : ST_CMUL;
      ST_WBA:  state_nxt = ST_WBB;
      ST_WBB:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == ST_WBA) || (state_r == ST_WBB)
                   || (state_r == ST_LDB && func_r == cir_pkg::FUNC_RD_BODY);
    end
  end

  // Table port.
  always_comb begin
    ram_we    = (state_r == ST_WBW) || (state_r == ST_WBA) || (state_r == ST_WBB);
    ram_raddr = (state_r == ST_RDB) ? AW'(b_r) : AW'(a_r);
    ram_waddr = (state_r == ST_WBB) ? AW'(b_r) : AW'(a_r);
    ram_wdata = '{pos_x: pa_r[0], pos_y: pa_r[1], pos_z: pa_r[2],
                  vel_x: va_r[0], vel_y: va_r[1], vel_z: va_r[2],
                  inv_mass: ima_r};
    case (state_r)
      ST_WBW: begin
        case (func_r)
          cir_pkg::FUNC_WR_POS: begin
            ram_wdata.pos_x = n_r[0];
            ram_wdata.pos_y = n_r[1];
            ram_wdata.pos_z = n_r[2];
          end
          cir_pkg::FUNC_WR_VEL: begin
            ram_wdata.vel_x = n_r[0];
            ram_wdata.vel_y = n_r[1];
            ram_wdata.vel_z = n_r[2];
          end
          default: ram_wdata.inv_mass = pen_r;
        endcase
      end
      ST_WBB: begin
        ram_wdata = '{pos_x: pb_r[0], pos_y: pb_r[1], pos_z: pb_r[2],
                      vel_x: vb_r[0], vel_y: vb_r[1], vel_z: vb_r[2],
                      inv_mass: imb_r};
      end
      default: ;
    endcase
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          func_r <= in_func;
          a_r    <= body_map[in_body_a];
          b_r    <= body_map[in_body_b];
          same_r <= (body_map[in_body_a] == body_map[in_body_b]);
          n_r[0] <= in_vec_x;
          n_r[1] <= in_vec_y;
          n_r[2] <= in_vec_z;
          pen_r  <= in_scalar;
        end
      end
      ST_RDB: begin
        pa_r[0] <= ram_rdata.pos_x;
        pa_r[1] <= ram_rdata.pos_y;
        pa_r[2] <= ram_rdata.pos_z;
        va_r[0] <= ram_rdata.vel_x;
        va_r[1] <= ram_rdata.vel_y;
        va_r[2] <= ram_rdata.vel_z;
        ima_r   <= ram_rdata.inv_mass;
      end
      ST_LDB: begin
        pb_r[0] <= ram_rdata.pos_x;
        pb_r[1] <= ram_rdata.pos_y;
        pb_r[2] <= ram_rdata.pos_z;
        vb_r[0] <= ram_rdata.vel_x;
        vb_r[1] <= ram_rdata.vel_y;
        vb_r[2] <= ram_rdata.vel_z;
        imb_r   <= ram_rdata.inv_mass;
        acc_r   <= '0;
        k_r     <= '0;
        out_last_r   <= 1'b1;
        out_body_r   <= a_r;
        out_pos_r[0] <= pa_r[0];
        out_pos_r[1] <= pa_r[1];
        out_pos_r[2] <= pa_r[2];
        out_vel_r[0] <= va_r[0];
        out_vel_r[1] <= va_r[1];
        out_vel_r[2] <= va_r[2];
      end
      ST_RACC: begin
        acc_r <= acc_r + cir_pkg::ACC_W'(prod_sh);
        k_r   <= (k_r == LAST_AXIS) ? 2'd0 : k_r + 2'd1;
      end
      ST_JDWT: begin
        if (div_stat.done) begin
          j_r <= sat_q(div_q, 1'b0);
        end
      end
      ST_IMPS: imp_r <= cir_pkg::sat32(cir_pkg::ACC_W'(prod_sh));
      ST_VAU:  va_r[k_r] <= cir_pkg::sat32(cir_pkg::ACC_W'(va_k - prod_sh));
      ST_VBU: begin
        // When both ends name one body, B starts from A's fresh value.
        vb_r[k_r] <= cir_pkg::sat32(cir_pkg::ACC_W'((same_r ? va_k : vb_k) + prod_sh));
        k_r       <= (k_r == LAST_AXIS) ? 2'd0 : k_r + 2'd1;
      end
      ST_CDS:  cd_r <= cir_pkg::sat32(cir_pkg::ACC_W'(prod_sh));
      ST_CDST: cneg_r <= prod[cir_pkg::PROD_W-1];
      ST_CDWT: begin
        if (div_stat.done) begin
          c_r <= sat_q(div_q, cneg_r);
        end
      end
      ST_PAU:  pa_r[k_r] <= cir_pkg::sat32(cir_pkg::ACC_W'(pa_k - prod_sh));
      ST_PBU: begin
        pb_r[k_r] <= cir_pkg::sat32(cir_pkg::ACC_W'((same_r ? pa_k : pb_k) + prod_sh));
        k_r       <= (k_r == LAST_AXIS) ? 2'd0 : k_r + 2'd1;
      end
      ST_WBA: begin
        // With one body at both ends the B copy holds the final entry.
        out_last_r   <= 1'b0;
        out_body_r   <= a_r;
        out_pos_r[0] <= same_r ? pb_r[0] : pa_r[0];
        out_pos_r[1] <= same_r ? pb_r[1] : pa_r[1];
        out_pos_r[2] <= same_r ? pb_r[2] : pa_r[2];
        out_vel_r[0] <= same_r ? vb_r[0] : va_r[0];
        out_vel_r[1] <= same_r ? vb_r[1] : va_r[1];
        out_vel_r[2] <= same_r ? vb_r[2] : va_r[2];
      end
      ST_WBB: begin
        out_last_r   <= 1'b1;
        out_body_r   <= b_r;
        out_pos_r[0] <= pb_r[0];
        out_pos_r[1] <= pb_r[1];
        out_pos_r[2] <= pb_r[2];
        out_vel_r[0] <= vb_r[0];
        out_vel_r[1] <= vb_r[1];
        out_vel_r[2] <= vb_r[2];
      end
      default: ;
    endcase
  end

  assign out_strobe = out_strobe_r;
  assign out_last   = out_last_r;
  assign out_body   = out_body_r;
  assign out_pos_x  = out_pos_r[0];
  assign out_pos_y  = out_pos_r[1];
  assign out_pos_z  = out_pos_r[2];
  assign out_vel_x  = out_vel_r[0];
  assign out_vel_y  = out_vel_r[1];
  assign out_vel_z  = out_vel_r[2];

`ifndef SYNTH
  // Every accepted command keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // The body A beat of a contact is followed at once by the body B beat.
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe && out_last)
    else $error("contact result pair broken");

  // A result beat only follows a write-back or read-back step.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == ST_WBA || state_r == ST_WBB || state_r == ST_LDB))
    else $error("result strobe without a reporting step");

  // The divider only runs while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy || div_stat.done |-> state_r == ST_JDWT || state_r == ST_CDWT)
    else $error("divider active outside a division wait");
`endif

endmodule

@@ rtl/core/cir_ram.sv @@
// ----------------------------------------------------------------------------
// cir_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/cir_mul.sv @@
// ----------------------------------------------------------------------------
// cir_mul: shared signed multiplier
// Every product of the contact arithmetic passes through this one unit.
// ----------------------------------------------------------------------------
module cir_mul (
  input  logic                              clk,
  input  logic signed [cir_pkg::MUL_W-1:0]  a,
  input  logic signed [cir_pkg::MUL_W-1:0]  b,
  output logic signed [cir_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

@@ rtl/core/cir_div.sv @@
// ----------------------------------------------------------------------------
// cir_div: restoring unsigned divider, one quotient bit per cycle
// Takes a magnitude and a divisor on start, pulses done with the quotient.
// ----------------------------------------------------------------------------
module cir_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [cir_pkg::DVD_W-1:0]        dividend,
  input  logic [cir_pkg::DVS_W-1:0]        divisor,
  output cir_pkg::div_stat_t               stat,
  output logic [cir_pkg::DVD_W-1:0]        quotient
);

  localparam int CW = $clog2(cir_pkg::DVD_W);

  logic                        busy_r;
  logic                        done_r;
  logic [CW-1:0]               cnt_r;
  logic [cir_pkg::DVS_W-1:0]   rem_r;
  logic [cir_pkg::DVD_W-1:0]   qd_r;
  logic [cir_pkg::DVS_W-1:0]   dvs_r;
  logic [cir_pkg::DVS_W:0]     trial;
  logic                        take;

  assign trial = {rem_r, qd_r[cir_pkg::DVD_W-1]};
  assign take  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(cir_pkg::DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      qd_r  <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? cir_pkg::DVS_W'(trial - {1'b0, dvs_r}) : trial[cir_pkg::DVS_W-1:0];
      qd_r  <= {qd_r[cir_pkg::DVD_W-2:0], take};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = qd_r;

endmodule

@@ test/tb_contact_impulse_resolver.sv @@
// ----------------------------------------------------------------------------
// tb_contact_impulse_resolver: self-checking bench for the contact resolver
// Loads every body, then runs directed and random load, read-back and
// contact beats under several register settings. A scoreboard class holds
// its own copy of the body table and predicts every result beat in order.
// ----------------------------------------------------------------------------
module tb_contact_impulse_resolver;
  import cir_pkg::*;

  // One result beat as the block reports it.
  typedef struct {
    logic [5:0]         body;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] vel_x, vel_y, vel_z;
    logic               last;
  } body_report_t;

  // The scoreboard keeps a shadow of the body table and the three
  // registers, works out the result beats of each accepted command and
  // checks the beats that come out against them, oldest first.
  class contact_scoreboard;
    longint pos[64][3];
    longint vel[64][3];
    longint inv_mass[64];
    longint restitution = RESTITUTION_RST;
    longint percent     = PERCENT_RST;
    longint slop        = SLOP_RST;
    body_report_t pending_reports[$];
    int errors = 0;

    function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void set_register(logic [1:0] idx, longint value);
      case (idx)
        REG_RESTITUTION: restitution = value & 'h1FFFF;
        REG_PERCENT:     percent     = value & 'h1FFFF;
        REG_SLOP:        slop        = value & 'h7FFFFFFF;
        default: ;
      endcase
    endfunction

    function void push_report(int idx, logic last);
      body_report_t r;
      r.body  = idx[5:0];
      r.pos_x = pos[idx][0]; r.pos_y = pos[idx][1]; r.pos_z = pos[idx][2];
      r.vel_x = vel[idx][0]; r.vel_y = vel[idx][1]; r.vel_z = vel[idx][2];
      r.last  = last;
      pending_reports.push_back(r);
    endfunction

    // Impulse along the normal first, then the positional fix-up. Body A is
    // written before B, so a body in contact with itself sees both updates.
    function void resolve_contact(int a, int b, longint n[3], longint depth);
      longint van, sum, j, imp, cd, c, excess;
      longint ima, imb;
      ima = inv_mass[a];
      imb = inv_mass[b];
      van = 0;
      for (int i = 0; i < 3; i++)
        van += (sat32(vel[b][i] - vel[a][i]) * n[i]) >>> 16;
      van = sat32(van);
      if (van > 0) return;          // bodies already separating
      sum = ima + imb;
      if (sum == 0) return;         // two immovable bodies
      j = sat32(((64'sd65536 + restitution) * (-van)) / sum);
      for (int i = 0; i < 3; i++) begin
        imp = sat32((n[i] * j) >>> 16);
        vel[a][i] = sat32(vel[a][i] - ((imp * ima) >>> 16));
        vel[b][i] = sat32(vel[b][i] + ((imp * imb) >>> 16));
      end
      excess = depth - slop;
      if (excess < 0) excess = 0;
      cd = sat32((excess * percent) >>> 16);
      for (int i = 0; i < 3; i++) begin
        c = sat32((n[i] * cd) / sum);
        pos[a][i] = sat32(pos[a][i] - ((c * ima) >>> 16));
        pos[b][i] = sat32(pos[b][i] + ((c * imb) >>> 16));
      end
    endfunction

    function void note_command(logic [2:0] func, logic [5:0] a, logic [5:0] b,
                               logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, logic [30:0] s);
      longint v[3];
      v[0] = x; v[1] = y; v[2] = z;
      case (func)
        FUNC_WR_POS: for (int i = 0; i < 3; i++) pos[a][i] = v[i];
        FUNC_WR_VEL: for (int i = 0; i < 3; i++) vel[a][i] = v[i];
        FUNC_WR_IM:  inv_mass[a] = s;
        FUNC_CONTACT: begin
          resolve_contact(a, b, v, s);
          push_report(a, 1'b0);
          push_report(b, 1'b1);
        end
        FUNC_RD_BODY: push_report(a, 1'b1);
        default: ;                  // unused codes are ignored
      endcase
    endfunction

    function void compare(string name, longint e, longint act);
      if (e != act) begin
        $error("%s: expected %0d, got %0d", name, e, act);
        errors++;
      end
    endfunction

    function void check_report(body_report_t r);
      body_report_t e;
      if (pending_reports.size() == 0) begin
        $error("result beat for body %0d with none expected", r.body);
        errors++;
        return;
      end
      e = pending_reports.pop_front();
      compare("body",      e.body,  r.body);
      compare("out_pos_x", e.pos_x, r.pos_x);
      compare("out_pos_y", e.pos_y, r.pos_y);
      compare("out_pos_z", e.pos_z, r.pos_z);
      compare("out_vel_x", e.vel_x, r.vel_x);
      compare("out_vel_y", e.vel_y, r.vel_y);
      compare("out_vel_z", e.vel_z, r.vel_z);
      compare("last",      e.last,  r.last);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_func = '0;
  logic [5:0]         in_body_a = '0, in_body_b = '0;
  logic signed [31:0] in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic [30:0]        in_scalar = '0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               out_strobe;
  logic [5:0]         out_body;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_vel_x, out_vel_y, out_vel_z;
  logic               out_last;

  contact_scoreboard sb = new();
  bit idling_on = 1'b1;

  contact_impulse_resolver u_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // The receiver cannot hold results off: every strobe is a result beat.
  always @(posedge clk) begin
    body_report_t r;
    if (out_strobe) begin
      r.body  = out_body;
      r.pos_x = out_pos_x; r.pos_y = out_pos_y; r.pos_z = out_pos_z;
      r.vel_x = out_vel_x; r.vel_y = out_vel_y; r.vel_z = out_vel_z;
      r.last  = out_last;
      sb.check_report(r);
    end
  end

  // Drives one command beat at the falling edge and holds it until the
  // block takes it; an idle gap may come first.
  task automatic issue(logic [2:0] func, logic [5:0] a, logic [5:0] b,
                       logic signed [31:0] x, logic signed [31:0] y,
                       logic signed [31:0] z, logic [30:0] s);
    if (idling_on && $urandom_range(0, 99) < 38) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
    @(negedge clk);
    start = 1'b1;
    in_func = func; in_body_a = a; in_body_b = b;
    in_vec_x = x; in_vec_y = y; in_vec_z = z; in_scalar = s;
    do @(posedge clk); while (busy);
    sb.note_command(func, a, b, x, y, z, s);
  endtask

  // Waits for every expected beat, then lets a load beat that gives no
  // result run out before the block counts as idle.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // Mixes full-range words, extremes and values near one.
  function automatic logic signed [31:0] any_word();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2:       return $signed($urandom_range(0, 2000000)) - 1000000;
      default: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
    endcase
  endfunction

  function automatic logic signed [31:0] normal_part();
    if ($urandom_range(0, 9) == 0) return any_word();
    return $signed($urandom_range(0, 131072)) - 65536;
  endfunction

  function automatic logic [30:0] any_mass();
    case ($urandom_range(0, 7))
      0, 1:    return '0;
      2:       return $urandom();
      default: return $urandom_range(1, 1 << 18);
    endcase
  endfunction

  function automatic logic [30:0] any_depth();
    case ($urandom_range(0, 4))
      0:       return $urandom();
      1:       return $urandom_range(0, 1000);
      default: return $urandom_range(0, 1 << 17);
    endcase
  endfunction

  task automatic random_command();
    int pick;
    logic [5:0] a, b;
    pick = $urandom_range(0, 99);
    a = $urandom();
    b = $urandom();
    if (pick < 10)
      issue(FUNC_WR_POS, a, b, any_word(), any_word(), any_word(), $urandom());
    else if (pick < 22)
      issue(FUNC_WR_VEL, a, b, any_word(), any_word(), any_word(), $urandom());
    else if (pick < 30)
      issue(FUNC_WR_IM, a, b, $urandom(), $urandom(), $urandom(), any_mass());
    else if (pick < 85)
      issue(FUNC_CONTACT, a, ($urandom_range(0, 19) == 0) ? a : b,
            normal_part(), normal_part(), normal_part(), any_depth());
    else if (pick < 97)
      issue(FUNC_RD_BODY, a, b, $urandom(), $urandom(), $urandom(), $urandom());
    else
      issue(3'($urandom_range(5, 7)), a, b, $urandom(), $urandom(), $urandom(),
            $urandom());
  endtask

  task automatic phase(logic [16:0] rest, logic [16:0] pct, logic [30:0] slp,
                       int beats, int calm_from);
    drain();
    write_register(REG_RESTITUTION, 32'(rest));
    write_register(REG_PERCENT, 32'(pct));
    write_register(REG_SLOP, 32'(slp));
    for (int n = 0; n < beats; n++) begin
      // A stretch with the sender never pausing.
      idling_on = !(n >= calm_from && n < calm_from + 150);
      // Once per phase the sender waits for every result to come back.
      if (n == beats / 2) drain();
      random_command();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Every body gets position, velocity and inverse mass before any read.
    for (int i = 0; i < 64; i++) begin
      issue(FUNC_WR_POS, 6'(i), '0, any_word(), any_word(), any_word(), '0);
      issue(FUNC_WR_VEL, 6'(i), '0, any_word(), any_word(), any_word(), '0);
      issue(FUNC_WR_IM, 6'(i), '0, '0, '0, '0, any_mass());
    end

    // Directed: extreme loads and read-back of the end bodies.
    issue(FUNC_WR_POS, 6'd63, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, '1);
    issue(FUNC_WR_VEL, 6'd63, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF, -32'sd1, '0);
    issue(FUNC_WR_IM, 6'd63, 6'd63, '1, '1, '1, 31'h7FFF_FFFF);
    issue(FUNC_RD_BODY, 6'd63, 6'd63, '0, '0, '0, '0);
    issue(FUNC_RD_BODY, 6'd0, 6'd63, '1, '1, '1, '1);
    // Two immovable bodies closing on each other: the contact is skipped.
    issue(FUNC_WR_IM, 6'd1, 6'd0, '0, '0, '0, '0);
    issue(FUNC_WR_IM, 6'd2, 6'd0, '0, '0, '0, '0);
    issue(FUNC_WR_VEL, 6'd1, 6'd0, 32'sd65536, '0, '0, '0);
    issue(FUNC_WR_VEL, 6'd2, 6'd0, -32'sd65536, '0, '0, '0);
    issue(FUNC_CONTACT, 6'd1, 6'd2, 32'sd65536, '0, '0, 31'd65536);
    // Separating bodies: the table is left as it was.
    issue(FUNC_WR_IM, 6'd1, 6'd0, '0, '0, '0, 31'd65536);
    issue(FUNC_CONTACT, 6'd2, 6'd1, 32'sd65536, '0, '0, 31'd65536);
    // Closing contact, ordinary values, then zero and full-scale depth.
    issue(FUNC_CONTACT, 6'd1, 6'd2, 32'sd65536, '0, '0, 31'd65536);
    issue(FUNC_CONTACT, 6'd1, 6'd2, '0, 32'sd65536, '0, 31'd0);
    issue(FUNC_CONTACT, 6'd1, 6'd63, '0, '0, -32'sd65536, 31'h7FFF_FFFF);
    // Extreme normals and a body in contact with itself.
    issue(FUNC_CONTACT, 6'd63, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h7FFF_FFFF, 31'h7FFF_FFFF);
    issue(FUNC_CONTACT, 6'd0, 6'd63, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 31'h7FFF_FFFF);
    issue(FUNC_CONTACT, 6'd5, 6'd5, 32'sd46341, 32'sd46341, '0, 31'd40000);
    // Unused function codes give no result.
    issue(3'd5, 6'd1, 6'd2, '1, '1, '1, '1);
    issue(3'd6, 6'd1, 6'd2, '0, '0, '0, '0);
    issue(3'd7, 6'd1, 6'd2, '1, '0, '1, '0);

    // Register settings, extremes first, then random, then the reset values.
    phase(17'd0, 17'd0, 31'd0, 420, 100);
    phase(17'd65536, 17'd65536, 31'h7FFF_FFFF, 420, 1000);
    phase(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
          31'($urandom_range(0, 200000)), 420, 1000);
    phase(RESTITUTION_RST, PERCENT_RST, SLOP_RST, 420, 1000);

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (sb.pending_reports.size() != 0)
        $error("%0d result beats never arrived", sb.pending_reports.size());
      $display("simulation failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every beat a contact with the
  // longest sender gaps still ends well before this.
  initial begin
    #60000000;
    $display("simulation failed");
    $finish;
  end

endmodule
